// ----- sv/ahtf_pkg.sv -----
// Shared types and constants for the AX.25 HDLC transmit framer.
// No dependencies; every other file of the block imports this package.
package ahtf_pkg;

    localparam logic [15:0] FCS_POLY  = 16'h8408;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [2:0]  LAST_BIT  = 3'd7;
    localparam logic [2:0]  STUFF_AT  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } ahtf_in_t;

    typedef struct packed {
        logic line_level;
        logic last_of_run;
    } ahtf_out_t;

    // One queued item after classification by the front end.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_frame;
        logic       end_of_frame;
    } ahtf_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ahtf_q_status_t;

    // One step of the reflected CRC-16 for a single input bit.
    function automatic logic [15:0] fcs_step(input logic [15:0] fcs, input logic bit_in);
        logic [15:0] shifted;
        shifted = {1'b0, fcs[15:1]};
        if (fcs[0] != bit_in) begin
            shifted = shifted ^ FCS_POLY;
        end
        return shifted;
    endfunction

endpackage

// ----- sv/ahtf_front.sv -----
// Front end of the framer: accepts input transfers and marks frame starts.
// Depends on ahtf_pkg; feeds ahtf_queue.
module ahtf_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  ahtf_pkg::ahtf_in_t      s_payload,
    input  ahtf_pkg::ahtf_q_status_t q_stat,
    output logic                    q_push,
    output ahtf_pkg::ahtf_entry_t   q_entry
);
    import ahtf_pkg::*;

    logic in_frame_reg;
    logic in_frame_next;

    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_entry.data_byte      = s_payload.data_byte;
        q_entry.start_of_frame = !in_frame_reg;
        q_entry.end_of_frame   = s_payload.end_of_frame;
        in_frame_next          = in_frame_reg;
        if (q_push) begin
            in_frame_next = !s_payload.end_of_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

// ----- sv/ahtf_queue.sv -----
// Two-entry queue of classified items between front end and serializer.
// Depends on ahtf_pkg.
module ahtf_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_push,
    input  ahtf_pkg::ahtf_entry_t    q_entry,
    input  logic                     q_pop,
    output ahtf_pkg::ahtf_entry_t    q_head,
    output ahtf_pkg::ahtf_q_status_t q_stat
);
    import ahtf_pkg::*;

    ahtf_entry_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_next;
    logic [1:0]  count_next;

    assign q_head       = slot_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == 2'd0);
    assign q_stat.full  = (count_reg == 2'd2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (q_push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!q_push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            slot_reg[wr_ptr_reg] <= q_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/ahtf_back.sv -----
// Serializer: flags, bit stuffing, FCS and NRZI, one line bit per cycle unless the output is stalled.
// Depends on ahtf_pkg; drains ahtf_queue and drives the output register.
module ahtf_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ahtf_pkg::ahtf_entry_t    q_head,
    input  ahtf_pkg::ahtf_q_status_t q_stat,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output ahtf_pkg::ahtf_out_t      m_payload
);
    import ahtf_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN,
        PH_DATA,
        PH_FCS_LO,
        PH_FCS_HI,
        PH_CLOSE,
        PH_TAIL
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [2:0]  ones_reg,   ones_next;
    logic [15:0] fcs_reg,    fcs_next;
    logic        level_reg,  level_next;
    logic        stuff_reg,  stuff_next;
    logic        eof_reg,    eof_next;
    logic        m_valid_reg, m_valid_next;
    ahtf_out_t   m_payload_reg, m_payload_next;

    logic        advance;
    logic        line_bit;
    logic        last_bit;
    logic        done;
    logic        load;
    logic        level_new;
    logic [15:0] fcs_upd;

    assign advance   = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        ones_next      = ones_reg;
        fcs_next       = fcs_reg;
        level_next     = level_reg;
        stuff_next     = stuff_reg;
        eof_next       = eof_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        q_pop          = 1'b0;
        line_bit       = 1'b1;
        last_bit       = 1'b0;
        done           = 1'b0;
        load           = 1'b0;
        level_new      = level_reg;
        fcs_upd        = fcs_step(fcs_reg, shift_reg[0]);

        if (phase_reg == PH_IDLE) begin
            load = !q_stat.empty;
        end else if (advance) begin
            if (stuff_reg) begin
                // Stuffed zero after five content ones.
                line_bit   = 1'b0;
                stuff_next = 1'b0;
                ones_next  = 3'd0;
                if (phase_reg == PH_TAIL) begin
                    last_bit = 1'b1;
                    done     = 1'b1;
                end
            end else begin
                unique case (phase_reg)
                    PH_OPEN, PH_CLOSE: begin
                        line_bit = FLAG_BYTE[cnt_reg];
                        cnt_next = cnt_reg + 3'd1;
                        if (cnt_reg == LAST_BIT) begin
                            if (phase_reg == PH_OPEN) begin
                                phase_next = PH_DATA;
                            end else begin
                                last_bit  = 1'b1;
                                done      = 1'b1;
                                ones_next = 3'd0;
                                fcs_next  = FCS_INIT;
                            end
                        end
                    end
                    PH_DATA, PH_FCS_LO, PH_FCS_HI: begin
                        line_bit   = shift_reg[0];
                        shift_next = {1'b0, shift_reg[7:1]};
                        cnt_next   = cnt_reg + 3'd1;
                        if (phase_reg == PH_DATA) begin
                            fcs_next = fcs_upd;
                        end
                        if (shift_reg[0]) begin
                            if (ones_reg == STUFF_AT) begin
                                ones_next  = 3'd0;
                                stuff_next = 1'b1;
                            end else begin
                                ones_next = ones_reg + 3'd1;
                            end
                        end else begin
                            ones_next = 3'd0;
                        end
                        if (cnt_reg == LAST_BIT) begin
                            unique case (phase_reg)
                                PH_DATA: begin
                                    if (eof_reg) begin
                                        phase_next = PH_FCS_LO;
                                        shift_next = ~fcs_upd[7:0];
                                    end else if (stuff_next) begin
                                        phase_next = PH_TAIL;
                                    end else begin
                                        last_bit = 1'b1;
                                        done     = 1'b1;
                                    end
                                end
                                PH_FCS_LO: begin
                                    phase_next = PH_FCS_HI;
                                    shift_next = ~fcs_reg[15:8];
                                end
                                default: begin
                                    phase_next = PH_CLOSE;
                                end
                            endcase
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end

            level_new      = line_bit ? level_reg : !level_reg;
            level_next     = level_new;
            m_valid_next   = 1'b1;
            m_payload_next = '{line_level: level_new, last_of_run: last_bit};
            if (done) begin
                phase_next = PH_IDLE;
                load       = !q_stat.empty;
            end
        end

        if (load) begin
            q_pop      = 1'b1;
            phase_next = q_head.start_of_frame ? PH_OPEN : PH_DATA;
            shift_next = q_head.data_byte;
            eof_next   = q_head.end_of_frame;
            cnt_next   = 3'd0;
            if (q_head.start_of_frame) begin
                fcs_next   = FCS_INIT;
                ones_next  = 3'd0;
                level_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= 3'd0;
            ones_reg    <= 3'd0;
            fcs_reg     <= FCS_INIT;
            level_reg   <= 1'b0;
            stuff_reg   <= 1'b0;
            eof_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            ones_reg    <= ones_next;
            fcs_reg     <= fcs_next;
            level_reg   <= level_next;
            stuff_reg   <= stuff_next;
            eof_reg     <= eof_next;
            m_valid_reg <= m_valid_next;
        end
        shift_reg     <= shift_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

// ----- sv/ax25_hdlc_tx_framer_top.sv -----
// AX.25 HDLC transmit framer. Each accepted byte is queued, then loaded into the serializer.
// Throughput: one line bit per cycle unless stalled; a content byte gives 8 line bits plus one
// per stuffed zero, the first byte of a frame 8 more for the opening flag, the last 24 more plus
// stuffed FCS bits, all put into the output register by the serializer, which sets the rate.
// Reset (aresetn low, synchronous) empties the queue, clears the frame state, sets the FCS to
// all ones and drops m_valid; no line bits are produced until a byte is accepted.
module ax25_hdlc_tx_framer_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ahtf_pkg::ahtf_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output ahtf_pkg::ahtf_out_t m_payload
);
    import ahtf_pkg::*;

    // The front end only decides whether a byte opens a new frame; that needs just the
    // end-of-frame mark of the previous transfer, so that decision never waits on the serializer.
    logic           q_push;
    logic           q_pop;
    ahtf_entry_t    q_entry;
    ahtf_entry_t    q_head;
    ahtf_q_status_t q_stat;

    ahtf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // The two-entry queue lets the next byte be taken while the current one is still
    // being shifted out, so upstream is stalled only once two bytes are waiting.
    ahtf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_stat  (q_stat)
    );

    // The serializer pulls the next queued byte in the same cycle that it finishes the
    // current one, so consecutive bytes stream out with no gap on the line.
    ahtf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_head    (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ----- sv/ahtf_checker.sv -----
// Port-level checks for the AX.25 HDLC transmit framer, bound to the top level.
// Depends on ahtf_pkg and ax25_hdlc_tx_framer_top.
module ahtf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ahtf_pkg::ahtf_out_t m_payload
);
    import ahtf_pkg::*;

    // Count of consecutive transferred line bits without a level change. Stuffing limits
    // content to five ones; a flag has six, and a frame start after idle may add one.
    logic       prev_level_reg;
    logic       seen_reg;
    logic [3:0] held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
            held_reg <= 4'd0;
        end else if (m_valid && m_ready) begin
            seen_reg <= 1'b1;
            if (seen_reg && (m_payload.line_level == prev_level_reg)) begin
                if (held_reg != 4'd15) begin
                    held_reg <= held_reg + 4'd1;
                end
            end else begin
                held_reg <= 4'd0;
            end
        end
        if (m_valid && m_ready) begin
            prev_level_reg <= m_payload.line_level;
        end
    end

    a_reset_no_output: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("s_ready low right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed or dropped while stalled");

    a_stuffing_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= 4'd7)
        else $error("too many line bits without a transition");

endmodule

bind ax25_hdlc_tx_framer_top ahtf_checker u_ahtf_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the AX.25 HDLC transmit framer (ax25_hdlc_tx_framer_top).
// Depends on ahtf_pkg for the transfer payload types and the FCS and flag constants.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ahtf_pkg::*;

    // Run-length guard. The slowest correct run is about 320 bytes times 44 line bits,
    // each possibly held up by receiver stalls, plus sender gaps and the long hold.
    // The limit leaves a wide margin above that.
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 600;
    // An accepted byte is queued and then loaded into the serializer before its first line bit.
    // This slack is the quiet time allowed after the last expected line bit.
    localparam int DRAIN_SLACK = 16;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ahtf_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ahtf_out_t m_payload;

    ax25_hdlc_tx_framer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Framer model. This is the independent copy of the framing state. It
    // is advanced once for every byte that the block accepts.
    // ------------------------------------------------------------------
    logic [15:0] tx_crc = FCS_INIT;
    logic [2:0]  ones_seen = '0;
    logic        line_lvl = 1'b0;
    logic        framing = 1'b0;

    logic      run_levels[$];
    ahtf_out_t pending_line_bits[$];

    int mismatches = 0;
    int bytes_accepted = 0;
    int frames_closed = 0;
    int line_bits_checked = 0;
    int input_stall_cycles = 0;
    int cycle_count = 0;

    // Shared handshake flags between the test sequence and the receiver process.
    bit idle_on = 1'b1;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;

    // A zero on the line toggles the level, and a one keeps it.
    task automatic emit_level(input logic b);
        if (!b) begin
            line_lvl = ~line_lvl;
        end
        run_levels.push_back(line_lvl);
    endtask

    // Flag bits bypass the stuffer and the FCS.
    task automatic emit_flag();
        for (int i = 0; i < 8; i++) begin
            emit_level(FLAG_BYTE[i]);
        end
    endtask

    task automatic emit_stuffed_byte(input logic [7:0] v, input bit into_crc);
        logic b;
        for (int i = 0; i < 8; i++) begin
            b = v[i];
            if (into_crc) begin
                tx_crc = {1'b0, tx_crc[15:1]} ^ ((tx_crc[0] != b) ? FCS_POLY : 16'h0000);
            end
            emit_level(b);
            if (b) begin
                ones_seen = ones_seen + 3'd1;
                if (ones_seen == 3'd5) begin
                    emit_level(1'b0);
                    ones_seen = '0;
                end
            end else begin
                ones_seen = '0;
            end
        end
    endtask

    task automatic predict_line_bits(input ahtf_in_t item);
        logic [15:0] fcs_out;
        ahtf_out_t   e;
        run_levels.delete();
        if (!framing) begin
            tx_crc = FCS_INIT;
            ones_seen = '0;
            line_lvl = 1'b0;
            framing = 1'b1;
            emit_flag();
        end
        emit_stuffed_byte(item.data_byte, 1'b1);
        if (item.end_of_frame) begin
            fcs_out = tx_crc ^ FCS_INIT;
            emit_stuffed_byte(fcs_out[7:0], 1'b0);
            emit_stuffed_byte(fcs_out[15:8], 1'b0);
            emit_flag();
            framing = 1'b0;
            ones_seen = '0;
            tx_crc = FCS_INIT;
            frames_closed++;
        end
        foreach (run_levels[i]) begin
            e.line_level = run_levels[i];
            e.last_of_run = (i == run_levels.size() - 1);
            pending_line_bits.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge, where the inputs
    // driven at the falling edge are settled.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        ahtf_out_t want;
        if (m_valid && m_ready) begin
            if (pending_line_bits.size() == 0) begin
                report_mismatch($sformatf("line bit with nothing expected (level %b, last %b)",
                                          m_payload.line_level, m_payload.last_of_run));
            end else begin
                want = pending_line_bits.pop_front();
                line_bits_checked++;
                if (m_payload.line_level !== want.line_level) begin
                    report_mismatch($sformatf("line_level got %b want %b",
                                              m_payload.line_level, want.line_level));
                end
                if (m_payload.last_of_run !== want.last_of_run) begin
                    report_mismatch($sformatf("last_of_run got %b want %b",
                                              m_payload.last_of_run, want.last_of_run));
                end
            end
        end
        if (s_valid && s_ready) begin
            predict_line_bits(s_payload);
            bytes_accepted++;
        end
        if (s_valid && !s_ready && aresetn) begin
            input_stall_cycles++;
        end
    end

    // This is the watchdog. A hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d line bits still expected",
                     cycle_count, pending_line_bits.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It applies random stall bursts while idling is enabled. On
    // request it holds m_ready low until its count here reaches HOLD_CYCLES, so the
    // block backs up into its input.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_count;
        stall_left = 0;
        hold_count = 0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES) begin
                    hold_done <= 1'b1;
                end
            end else begin
                if (!hold_request) begin
                    hold_count = 0;
                    hold_done <= 1'b0;
                end
                if (stall_left > 0) begin
                    m_ready <= 1'b0;
                    stall_left--;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    m_ready <= 1'b0;
                    stall_left = $urandom_range(1, 7) - 1;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Each call starts and ends at a falling edge. The valid
    // signal stays high between back-to-back transfers.
    // ------------------------------------------------------------------
    task automatic send_content_byte(input logic [7:0] b, input logic eof);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_payload.data_byte <= b;
        s_payload.end_of_frame <= eof;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // The sender goes quiet until every expected line bit has been received.
    task automatic wait_for_line_drain();
        s_valid <= 1'b0;
        while (pending_line_bits.size() != 0) @(negedge aclk);
        repeat (DRAIN_SLACK) @(negedge aclk);
    endtask

    // Content is weighted toward long runs of ones and flag-like patterns
    // because stuffing decisions are made there.
    function automatic logic [7:0] pick_content_byte();
        case ($urandom_range(0, 7))
            0, 1: return 8'hFF;
            2:    return FLAG_BYTE;
            3:    return ($urandom_range(0, 1) != 0) ? 8'hF8 : 8'h1F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_frame(input int len);
        for (int i = 0; i < len; i++) begin
            send_content_byte(pick_content_byte(), i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A byte that both opens and closes a frame produces the whole frame in one run.
    task automatic test_single_byte_frames();
        send_content_byte(8'h00, 1'b1);
        send_content_byte(8'hFF, 1'b1);
        send_content_byte(FLAG_BYTE, 1'b1);
    endtask

    // Runs of ones that cross byte boundaries, all-zero content, and a run of ones longer
    // than a flag's inside the frame that must be stuffed.
    task automatic test_bit_stuffing();
        send_content_byte(8'h1F, 1'b0);
        send_content_byte(8'hF0, 1'b0);
        send_content_byte(8'hFF, 1'b0);
        send_content_byte(8'h80, 1'b1);
        send_content_byte(8'h00, 1'b0);
        send_content_byte(8'h00, 1'b1);
        send_content_byte(8'hFE, 1'b0);
        send_content_byte(8'h7F, 1'b1);
    endtask

    // This is a header-like frame with shifted address octets, control 0x03 and
    // PID 0xF0, so the FCS covers a realistic mix.
    task automatic test_header_like_frame();
        send_content_byte(8'h82, 1'b0);
        send_content_byte(8'hA0, 1'b0);
        send_content_byte(8'h40, 1'b0);
        send_content_byte(8'h61, 1'b0);
        send_content_byte(8'h03, 1'b0);
        send_content_byte(8'hF0, 1'b0);
        send_content_byte(8'h55, 1'b0);
        send_content_byte(8'hAA, 1'b1);
        wait_for_line_drain();
    endtask

    // The receiver stops for a long stretch while a long frame keeps coming, so
    // the block fills and stalls its input.
    task automatic test_receiver_hold();
        hold_request = 1'b1;
        send_random_frame(24);
        while (!hold_done) @(negedge aclk);
        hold_request = 1'b0;
    endtask

    // Frames have random lengths and content. Idling is switched off for some
    // frames, and sometimes the sender waits for a full drain between frames.
    task automatic test_random_frames(input int byte_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < byte_budget) begin
            idle_on = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 10);
            send_random_frame(len);
            sent += len;
            if ($urandom_range(0, 5) == 0) begin
                wait_for_line_drain();
            end
        end
        idle_on = 1'b1;
    endtask

    // The closing stretch runs at full rate with no idling on either side.
    task automatic test_full_rate_tail(input int byte_budget);
        int sent;
        int len;
        idle_on = 1'b0;
        sent = 0;
        while (sent < byte_budget) begin
            len = $urandom_range(1, 8);
            send_random_frame(len);
            sent += len;
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_single_byte_frames();
        test_bit_stuffing();
        test_header_like_frame();
        test_receiver_hold();
        test_random_frames(240);
        test_full_rate_tail(40);

        s_valid <= 1'b0;
        while (pending_line_bits.size() != 0) @(negedge aclk);
        // Any line bit that shows up after this point is unexpected and gets flagged.
        repeat (DRAIN_SLACK) @(negedge aclk);

        $display("Covered %0d content bytes in %0d frames and checked %0d line bits.",
                 bytes_accepted, frames_closed, line_bits_checked);
        $display("The input was back-pressured for %0d cycles, with idle and full-rate stretches.",
                 input_stall_cycles);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- ax25_hdlc_tx_framer_top.f -----
sv/ahtf_pkg.sv
sv/ahtf_front.sv
sv/ahtf_queue.sv
sv/ahtf_back.sv
sv/ax25_hdlc_tx_framer_top.sv
sv/ahtf_checker.sv
tb/sv/tb.sv
